// File: hdl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

    // Frame layout
    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] TRAILER_BYTE = 8'hAA;
    localparam int         PAYLOAD_LEN  = 6;

    // Frame position: hunting, storing payload 1..6, expecting trailer
    localparam int POS_W = 3;
    typedef logic [POS_W-1:0] t_pos;
    localparam t_pos POS_HUNT    = 3'd0;
    localparam t_pos POS_TRAILER = 3'd7;

    // Payload byte slots
    localparam int SLOT_ENC_AB    = 0;
    localparam int SLOT_ENC_CD    = 1;
    localparam int SLOT_INTERVAL  = 2;
    localparam int SLOT_FLAGS     = 3;
    localparam int SLOT_LINE_DIR  = 4;
    localparam int SLOT_INNER_DIR = 5;

    // Decode constants
    localparam logic [9:0] DIR_OFFSET = 10'd180;
    localparam logic [7:0] DEPTH_BASE = 8'd24;

    typedef logic [7:0] t_payload [PAYLOAD_LEN];

    // Parser to result stage
    typedef struct packed {
        logic frame_good;
        logic at_trailer;
    } t_parse_status;

    // Byte to direction in degrees: b*2 - 180
    function automatic logic signed [9:0] direction_of(input logic [7:0] b);
        direction_of = signed'({1'b0, b, 1'b0} - DIR_OFFSET);
    endfunction

endpackage
`default_nettype wire

// File: hdl/sfd_ifs.sv
`default_nettype none
// Received byte channel
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Configuration write channel
interface sfd_cfg_if;
    logic valid;
    logic ready;
    logic led_on;
    modport source (output valid, output led_on, input ready);
    modport sink   (input valid, input led_on, output ready);
endinterface

// Decoded frame channel
interface sfd_result_if;
    logic              valid;
    logic              ready;
    logic [3:0]        encoder_a;
    logic [3:0]        encoder_b;
    logic [3:0]        encoder_c;
    logic [3:0]        encoder_d;
    logic [7:0]        line_interval;
    logic              on_line;
    logic              left_flag;
    logic              right_flag;
    logic signed [9:0] line_direction;
    logic signed [9:0] inner_direction;
    logic [7:0]        depth;
    logic              reply_byte;
    modport source (
        output valid, input ready,
        output encoder_a, output encoder_b, output encoder_c, output encoder_d,
        output line_interval, output on_line, output left_flag, output right_flag,
        output line_direction, output inner_direction, output depth, output reply_byte
    );
    modport sink (
        input valid, output ready,
        input encoder_a, input encoder_b, input encoder_c, input encoder_d,
        input line_interval, input on_line, input left_flag, input right_flag,
        input line_direction, input inner_direction, input depth, input reply_byte
    );
endinterface
`default_nettype wire

// File: hdl/sfd_parser.sv
`default_nettype none
module sfd_parser
    import sfd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    output t_parse_status      o_status,
    output t_payload           o_payload
);

    t_pos     r_pos;
    t_pos     n_pos;
    t_payload r_payload;

    // Next frame position
    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            priority if (r_pos == POS_HUNT) begin
                if (i_byte == HEADER_BYTE) begin
                    n_pos = 3'd1;
                end
            end else if (r_pos == POS_TRAILER) begin
                // trailer byte is never taken as a new header
                n_pos = POS_HUNT;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Payload store, slot i filled at position i+1
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (i_accept && r_pos == t_pos'(i + 1)) begin
                r_payload[i] <= i_byte;
            end
        end
    end

    assign o_status.at_trailer = (r_pos == POS_TRAILER);
    assign o_status.frame_good = i_accept && (r_pos == POS_TRAILER)
                                 && (i_byte == TRAILER_BYTE);
    assign o_payload = r_payload;

endmodule
`default_nettype wire

// File: hdl/sfd_result.sv
`default_nettype none
module sfd_result
    import sfd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_payload      i_payload,
    input  wire logic          i_led_on,
    sfd_result_if.source       o_res
);

    logic              r_valid;
    logic [3:0]        r_enc_a;
    logic [3:0]        r_enc_b;
    logic [3:0]        r_enc_c;
    logic [3:0]        r_enc_d;
    logic [7:0]        r_interval;
    logic [2:0]        r_flags;
    logic signed [9:0] r_line_dir;
    logic signed [9:0] r_inner_dir;
    logic [7:0]        r_depth;
    logic              r_reply;

    logic [7:0]        n_depth;

    // Depth folds around 24 when both directions agree
    always_comb begin
        if (i_payload[SLOT_LINE_DIR] == i_payload[SLOT_INNER_DIR]) begin
            n_depth = DEPTH_BASE - i_payload[SLOT_INTERVAL];
        end else begin
            n_depth = i_payload[SLOT_INTERVAL];
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Decoded fields
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_enc_a     <= i_payload[SLOT_ENC_AB][7:4];
            r_enc_b     <= i_payload[SLOT_ENC_AB][3:0];
            r_enc_c     <= i_payload[SLOT_ENC_CD][7:4];
            r_enc_d     <= i_payload[SLOT_ENC_CD][3:0];
            r_interval  <= i_payload[SLOT_INTERVAL];
            r_flags     <= i_payload[SLOT_FLAGS][2:0];
            r_line_dir  <= direction_of(i_payload[SLOT_LINE_DIR]);
            r_inner_dir <= direction_of(i_payload[SLOT_INNER_DIR]);
            r_depth     <= n_depth;
            r_reply     <= i_led_on;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.encoder_a       = r_enc_a;
    assign o_res.encoder_b       = r_enc_b;
    assign o_res.encoder_c       = r_enc_c;
    assign o_res.encoder_d       = r_enc_d;
    assign o_res.line_interval   = r_interval;
    assign o_res.on_line         = r_flags[2];
    assign o_res.left_flag       = r_flags[1];
    assign o_res.right_flag      = r_flags[0];
    assign o_res.line_direction  = r_line_dir;
    assign o_res.inner_direction = r_inner_dir;
    assign o_res.depth           = r_depth;
    assign o_res.reply_byte      = r_reply;

endmodule
`default_nettype wire

// File: hdl/sensor_frame_deframer.sv
// A frame's result is valid in the cycle after its trailer byte is accepted.
// Throughput: one byte per cycle when not stalled; set by the frame position counter and result register.
// The byte input stalls only on a trailer byte while an earlier result is still unread.
// Reset (i_rst_n low, synchronous): header hunt, no result pending, LED flag cleared.
// Payload store is not reset; every slot is rewritten before a trailer is checked.
`default_nettype none
module sensor_frame_deframer
    import sfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfd_byte_if.sink     i_rx_chan,
    sfd_cfg_if.sink      i_cfg_chan,
    sfd_result_if.source o_res_chan
);

    logic          r_led_on;
    logic          rx_accept;
    t_parse_status parse_status;
    t_payload      payload;

    // LED flag register, always writable
    assign i_cfg_chan.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_on <= 1'b0;
        end else if (i_cfg_chan.valid) begin
            r_led_on <= i_cfg_chan.led_on;
        end
    end

    // Hold a trailer byte only if the result register cannot take it
    assign i_rx_chan.ready = !(parse_status.at_trailer && o_res_chan.valid
                               && !o_res_chan.ready);
    assign rx_accept = i_rx_chan.valid && i_rx_chan.ready;

    sfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_byte    (i_rx_chan.rx_byte),
        .o_status  (parse_status),
        .o_payload (payload)
    );

    sfd_result u_result (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (parse_status.frame_good),
        .i_payload (payload),
        .i_led_on  (r_led_on),
        .o_res     (o_res_chan)
    );

endmodule
`default_nettype wire

// File: hdl/sfd_checker.sv
`default_nettype none
module sfd_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_rx_valid,
    input wire logic              i_rx_ready,
    input wire logic              i_res_valid,
    input wire logic              i_res_ready,
    input wire logic [7:0]        i_interval,
    input wire logic signed [9:0] i_line_dir,
    input wire logic signed [9:0] i_inner_dir,
    input wire logic [7:0]        i_depth
);

    // A stalled result keeps its transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_depth)
            && $stable(i_line_dir) && $stable(i_interval))
        else $error("stalled result changed");

    // A new result follows an accepted byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("result without an input transaction");

    // Directions are always even
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_line_dir[0] && !i_inner_dir[0])
        else $error("odd direction");

    // Depth folds when directions agree
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_line_dir == i_inner_dir) |-> i_depth == (8'd24 - i_interval))
        else $error("depth not folded");

    // Depth passes the interval when directions differ
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_line_dir != i_inner_dir) |-> i_depth == i_interval)
        else $error("depth differs from interval");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx_chan.valid),
    .i_rx_ready  (i_rx_chan.ready),
    .i_res_valid (o_res_chan.valid),
    .i_res_ready (o_res_chan.ready),
    .i_interval  (o_res_chan.line_interval),
    .i_line_dir  (o_res_chan.line_direction),
    .i_inner_dir (o_res_chan.inner_direction),
    .i_depth     (o_res_chan.depth)
);
`default_nettype wire

// File: tb/tb_sensor_frame_deframer.sv
`timescale 1ns / 100ps
module tb_sensor_frame_deframer;
    import sfd_pkg::*;

    // Decoded sensor frame as seen on the result channel
    typedef struct packed {
        logic [3:0]        encoder_a;
        logic [3:0]        encoder_b;
        logic [3:0]        encoder_c;
        logic [3:0]        encoder_d;
        logic [7:0]        line_interval;
        logic              on_line;
        logic              left_flag;
        logic              right_flag;
        logic signed [9:0] line_direction;
        logic signed [9:0] inner_direction;
        logic [7:0]        depth;
        logic              reply_byte;
    } t_frame;

    localparam int QUIET_LIMIT = 1000;  // cycles with no transaction at all
    localparam int IDLE_PCT    = 35;
    localparam int SETTLE_CYC  = 4;

    logic i_clk;
    logic i_rst_n;

    sfd_byte_if   rx_if ();
    sfd_cfg_if    cfg_if ();
    sfd_result_if res_if ();

    sensor_frame_deframer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_chan  (rx_if),
        .i_cfg_chan (cfg_if),
        .o_res_chan (res_if)
    );

    // Parser shadow state
    t_pos       parse_pos;
    logic [7:0] payload_buf [PAYLOAD_LEN];
    logic       led_shadow;

    t_frame decoded_q [$];
    bit     calm;          // no idling on either side
    int     errors;
    int     mismatches;
    int     bytes_fed;
    int     frames_checked;
    int     bad_trailers;
    int     led_writes;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Byte to degrees: b*2 - 180
    function automatic logic signed [9:0] to_degrees(input logic [7:0] b);
        logic [9:0] twice;
        twice = {1'b0, b, 1'b0};
        return signed'(twice - DIR_OFFSET);
    endfunction

    // Advance the parser shadow by one byte; returns 1 when a frame decodes
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_frame f);
        logic [7:0] interval;
        logic [7:0] flags;
        f = '0;
        if (parse_pos == POS_HUNT) begin
            if (b == HEADER_BYTE)
                parse_pos = parse_pos + 1'b1;
            return 1'b0;
        end
        if (parse_pos == POS_TRAILER) begin
            // trailer byte is never rechecked as a header
            parse_pos = POS_HUNT;
            if (b != TRAILER_BYTE) begin
                bad_trailers++;
                return 1'b0;
            end
            interval          = payload_buf[SLOT_INTERVAL];
            flags             = payload_buf[SLOT_FLAGS];
            f.encoder_a       = payload_buf[SLOT_ENC_AB][7:4];
            f.encoder_b       = payload_buf[SLOT_ENC_AB][3:0];
            f.encoder_c       = payload_buf[SLOT_ENC_CD][7:4];
            f.encoder_d       = payload_buf[SLOT_ENC_CD][3:0];
            f.line_interval   = interval;
            f.on_line         = flags[2];
            f.left_flag       = flags[1];
            f.right_flag      = flags[0];
            f.line_direction  = to_degrees(payload_buf[SLOT_LINE_DIR]);
            f.inner_direction = to_degrees(payload_buf[SLOT_INNER_DIR]);
            f.depth = (payload_buf[SLOT_LINE_DIR] == payload_buf[SLOT_INNER_DIR]) ?
                      8'(DEPTH_BASE - interval) : interval;
            f.reply_byte      = led_shadow;
            return 1'b1;
        end
        // payload byte, header value included, is plain data here
        payload_buf[int'(parse_pos) - 1] = b;
        parse_pos = parse_pos + 1'b1;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [9:0] want,
                                   input logic [9:0] got);
        mismatches++;
        errors++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    // Predict on each accepted byte, check each accepted frame
    always @(posedge i_clk) begin : scoreboard
        t_frame want;
        t_frame next_frame;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                led_shadow = cfg_if.led_on;
            if (res_if.valid && res_if.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected frame", '0, '1);
                end else begin
                    want = decoded_q.pop_front();
                    frames_checked++;
                    check_field("encoder_a", want.encoder_a, res_if.encoder_a);
                    check_field("encoder_b", want.encoder_b, res_if.encoder_b);
                    check_field("encoder_c", want.encoder_c, res_if.encoder_c);
                    check_field("encoder_d", want.encoder_d, res_if.encoder_d);
                    check_field("line_interval", want.line_interval, res_if.line_interval);
                    check_field("on_line", want.on_line, res_if.on_line);
                    check_field("left_flag", want.left_flag, res_if.left_flag);
                    check_field("right_flag", want.right_flag, res_if.right_flag);
                    check_field("line_direction", want.line_direction,
                                res_if.line_direction);
                    check_field("inner_direction", want.inner_direction,
                                res_if.inner_direction);
                    check_field("depth", want.depth, res_if.depth);
                    check_field("reply_byte", want.reply_byte, res_if.reply_byte);
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                if (parse_rx_byte(rx_if.rx_byte, next_frame))
                    decoded_q.push_back(next_frame);
            end
        end
    end

    // Result back-pressure
    always @(posedge i_clk)
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog on cycles with no transaction
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // One byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_fed++;
    endtask

    // Stop feeding and wait until every predicted frame has come out
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return HEADER_BYTE;
            2:       return TRAILER_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Extremes: all-zero payload, header value throughout payload, rejected trailer
    task automatic test_directed_frames();
        logic [7:0] seq [25];
        seq = '{8'h55,
                8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA,
                8'hFF, 8'h12, 8'h34, 8'h56, 8'h07, 8'h5A, 8'h5B, 8'hFF};
        calm = 1'b1;
        foreach (seq[i])
            send_byte(seq[i]);
        drain_results();
    endtask

    // LED flag register write, done only with the block idle
    task automatic test_led_write(input logic led);
        drain_results();
        cfg_if.valid  <= 1'b1;
        cfg_if.led_on <= led;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        led_writes++;
    endtask

    // Mostly well-formed frames with random content, some noise and bad trailers
    task automatic test_random_stream(input int n_bytes, input bit no_idle);
        int         first;
        int         n_noise;
        logic [7:0] payload [PAYLOAD_LEN];
        logic [7:0] trailer;
        calm  = no_idle;
        first = bytes_fed;
        while (bytes_fed - first < n_bytes) begin
            if ($urandom_range(99) < 80) begin
                n_noise = $urandom_range(2);
                repeat (n_noise) send_byte(8'($urandom_range(254)));
                foreach (payload[i])
                    payload[i] = pick_payload_byte();
                if ($urandom_range(3) == 0)
                    payload[SLOT_INNER_DIR] = payload[SLOT_LINE_DIR];
                trailer = TRAILER_BYTE;
                if ($urandom_range(99) < 15)
                    trailer = $urandom_range(1) ? HEADER_BYTE : 8'($urandom_range(255));
                send_byte(HEADER_BYTE);
                foreach (payload[i])
                    send_byte(payload[i]);
                send_byte(trailer);
                // a frame-like tail after a rejected trailer must not decode
                if (trailer != TRAILER_BYTE && $urandom_range(1)) begin
                    repeat (PAYLOAD_LEN) send_byte(pick_payload_byte());
                    send_byte(TRAILER_BYTE);
                end
            end else begin
                n_noise = $urandom_range(1, 8);
                repeat (n_noise) send_byte(8'($urandom_range(255)));
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        cfg_if.valid   = 1'b0;
        cfg_if.led_on  = 1'b0;
        res_if.ready   = 1'b0;
        calm           = 1'b0;
        parse_pos      = POS_HUNT;
        led_shadow     = 1'b0;
        errors         = 0;
        mismatches     = 0;
        bytes_fed      = 0;
        frames_checked = 0;
        bad_trailers   = 0;
        led_writes     = 0;
        foreach (payload_buf[i])
            payload_buf[i] = 8'h00;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_led_write(1'b1);
        test_random_stream(350, 1'b0);
        test_led_write(1'b0);
        test_random_stream(350, 1'b1);
        test_led_write(1'b1);
        test_random_stream(350, 1'b0);

        drain_results();
        if (decoded_q.size() != 0) begin
            errors += decoded_q.size();
            $display("%0d predicted frames never came out", decoded_q.size());
        end

        $display("Fed %0d bytes, checked %0d decoded frames, %0d trailers rejected.",
                 bytes_fed, frames_checked, bad_trailers);
        $display("LED flag written %0d times; %0d field mismatches.", led_writes, mismatches);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/sfd_pkg.sv
hdl/sfd_ifs.sv
hdl/sfd_parser.sv
hdl/sfd_result.sv
hdl/sensor_frame_deframer.sv
hdl/sfd_checker.sv
tb/tb_sensor_frame_deframer.sv
